// ===== hw/rtl/fbpa_pkg.sv =====
// Shared constants, codes and types of the fixed block pool allocator.
// No dependencies; imported by every module of the block but fbpa_ram.
package fbpa_pkg;

   // Pool geometry. BLOCK_BYTES must be a power of two.
   localparam int BLOCK_BYTES  = 64;
   localparam int NUM_BLOCKS   = 256;
   localparam int BLOCK_SHIFT  = $clog2(BLOCK_BYTES);
   localparam int IDX_W        = $clog2(NUM_BLOCKS);
   localparam int CNT_W        = $clog2(NUM_BLOCKS + 1);
   localparam int POOL_BYTES   = BLOCK_BYTES * NUM_BLOCKS;

   // Field widths
   localparam int ADDR_W       = 32;
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;
   localparam int FREE_COUNT_W = 9;

   localparam logic [ADDR_W-1:0] POOL_BASE_RESET = 32'd4096;
   localparam logic [CNT_W-1:0]  LIST_END        = CNT_W'(NUM_BLOCKS);

   // Operation codes
   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_RESET = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the request beat
      logic commit;    // apply the operation and load the result register
   } fbpa_cmd_type;

endpackage

// ===== hw/rtl/fbpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fbpa_ctrl.sv =====
// Controller of the pool allocator: accept/execute sequencing and result valid.
// Depends on fbpa_pkg.
module fbpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  csr_ready,
   output fbpa_pkg::fbpa_cmd_type cmd
);
   import fbpa_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // Result register can take a beat when empty or draining this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall   = (state_ff != S_IDLE);
   assign csr_ready   = (state_ff == S_IDLE);
   assign cmd.capture = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit  = (state_ff == S_EXEC) && out_free;
   assign rsp_valid   = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid: set on commit, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/fbpa_datapath.sv =====
// Datapath of the pool allocator: request latch, free-list registers,
// link RAM, pool base register and result payload. Depends on fbpa_pkg, fbpa_ram.
module fbpa_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  fbpa_pkg::fbpa_cmd_type          cmd,
   input  logic [fbpa_pkg::OP_W-1:0]       req_operation,
   input  logic [fbpa_pkg::ADDR_W-1:0]     req_request_size,
   input  logic [fbpa_pkg::ADDR_W-1:0]     req_address,
   input  logic                            csr_write,
   input  logic [fbpa_pkg::ADDR_W-1:0]     csr_data,
   output logic [fbpa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]     rsp_block_address,
   output logic                            rsp_owned,
   output logic [fbpa_pkg::FREE_COUNT_W-1:0] rsp_free_count
);
   import fbpa_pkg::*;

   // Request latch
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] size_ff;
   logic [ADDR_W-1:0] addr_ff;

   // Free-list state
   logic [ADDR_W-1:0] pool_base_ff;
   logic [CNT_W-1:0]  free_head_ff, free_head_in;
   logic [CNT_W-1:0]  fresh_index_ff, fresh_index_in;
   logic [CNT_W-1:0]  free_blocks_ff, free_blocks_in;

   // Result payload
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [ADDR_W-1:0]       blk_addr_ff, blk_addr_in;
   logic                    owned_ff;
   logic [FREE_COUNT_W-1:0] count_ff;

   logic [CNT_W-1:0]  link_rdata;
   logic [ADDR_W-1:0] offset;
   logic              owned;
   logic [IDX_W-1:0]  free_idx;
   logic [CNT_W-1:0]  alloc_idx;
   logic              link_we;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         size_ff <= req_request_size;
         addr_ff <= req_address;
      end
   end

   // Ownership: offset from base must fall inside the pool span
   assign offset   = addr_ff - pool_base_ff;
   assign owned    = (addr_ff != '0) && (pool_base_ff != '0) &&
                     (addr_ff >= pool_base_ff) &&
                     (offset < ADDR_W'(POOL_BYTES));
   assign free_idx = offset[BLOCK_SHIFT +: IDX_W];

   // Operation decode and free-list update
   always_comb begin
      free_head_in   = free_head_ff;
      fresh_index_in = fresh_index_ff;
      free_blocks_in = free_blocks_ff;
      status_in      = STATUS_OK;
      blk_addr_in    = '0;
      alloc_idx      = '0;
      link_we        = 1'b0;
      unique case (op_ff)
         OP_ALLOC: begin
            if (size_ff > ADDR_W'(BLOCK_BYTES)) begin
               status_in = STATUS_TOO_LARGE;
            end else if (pool_base_ff == '0) begin
               status_in = STATUS_EMPTY;
            end else begin
               priority if (free_head_ff < LIST_END) begin
                  alloc_idx    = free_head_ff;
                  free_head_in = (link_rdata > LIST_END) ? LIST_END : link_rdata;
               end else if (fresh_index_ff < LIST_END) begin
                  alloc_idx      = fresh_index_ff;
                  fresh_index_in = fresh_index_ff + 1'b1;
               end else begin
                  status_in = STATUS_EMPTY;
               end
               if (status_in == STATUS_OK) begin
                  blk_addr_in = pool_base_ff +
                                (ADDR_W'(alloc_idx) << BLOCK_SHIFT);
                  if (free_blocks_ff != '0) free_blocks_in = free_blocks_ff - 1'b1;
               end
            end
         end
         OP_FREE: begin
            if (!owned) begin
               status_in = STATUS_IGNORED;
            end else begin
               link_we      = 1'b1;
               free_head_in = CNT_W'(free_idx);
               if (free_blocks_ff < LIST_END) free_blocks_in = free_blocks_ff + 1'b1;
            end
         end
         OP_RESET: begin
            free_head_in   = LIST_END;
            fresh_index_in = '0;
            free_blocks_in = LIST_END;
         end
         OP_QUERY: begin
            status_in = STATUS_OK;
         end
         default: status_in = STATUS_OK;
      endcase
   end

   // Link RAM: read port always follows the list head
   fbpa_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && link_we),
      .wr_addr (free_idx),
      .wr_data (free_head_ff),
      .rd_addr (free_head_ff[IDX_W-1:0]),
      .rd_data (link_rdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= POOL_BASE_RESET;
         free_head_ff   <= LIST_END;
         fresh_index_ff <= '0;
         free_blocks_ff <= LIST_END;
      end else begin
         if (csr_write) pool_base_ff <= csr_data;
         if (cmd.commit) begin
            free_head_ff   <= free_head_in;
            fresh_index_ff <= fresh_index_in;
            free_blocks_ff <= free_blocks_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff   <= status_in;
         blk_addr_ff <= blk_addr_in;
         owned_ff    <= owned;
         count_ff    <= FREE_COUNT_W'(free_blocks_in);
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_block_address = blk_addr_ff;
   assign rsp_owned         = owned_ff;
   assign rsp_free_count    = count_ff;

endmodule

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator with a LIFO free list held in a link RAM.
// The request beat is latched when accepted and the result is registered in the
// execute state, which lasts longer only while a previous result beat is still stalled.
// No request beat is accepted while one executes, as the registered link RAM read
// at the list head is taken in the accept cycle and used in the execute cycle.
// Reset (synchronous): all blocks free in ascending order via a fresh-index
// counter, pool base 4096; no clearing pass, link RAM is left as is.
module fixed_block_pool_allocator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fbpa_pkg::OP_W-1:0]         req_operation,
   input  logic [fbpa_pkg::ADDR_W-1:0]       req_request_size,
   input  logic [fbpa_pkg::ADDR_W-1:0]       req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fbpa_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fbpa_pkg::ADDR_W-1:0]       rsp_block_address,
   output logic                              rsp_owned,
   output logic [fbpa_pkg::FREE_COUNT_W-1:0] rsp_free_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fbpa_pkg::ADDR_W-1:0]       csr_data
);
   import fbpa_pkg::*;

   fbpa_cmd_type cmd;

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .cmd       (cmd)
   );

   fbpa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_operation),
      .req_request_size  (req_request_size),
      .req_address       (req_address),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_owned         (rsp_owned),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

// ===== hw/rtl/fbpa_checker.sv =====
// Port-level checker for the pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
module fbpa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [fbpa_pkg::STATUS_W-1:0]     rsp_status,
   input logic [fbpa_pkg::ADDR_W-1:0]       rsp_block_address,
   input logic [fbpa_pkg::FREE_COUNT_W-1:0] rsp_free_count
);
   import fbpa_pkg::*;

   // A stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_block_address) && $stable(rsp_free_count))
      else $error("stalled result beat changed");

   // An accepted request keeps the input stalled during execute
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted during execute cycle");

   // Only a successful allocate carries a block address
   a_addr_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_block_address == '0)
      else $error("failed operation returned a block address");

   // Free count never exceeds the pool size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_count <= FREE_COUNT_W'(NUM_BLOCKS))
      else $error("free count above pool size");

   // No result is pending out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_block_address (rsp_block_address),
   .rsp_free_count    (rsp_free_count)
);

// ===== test/fixed_block_pool_allocator_test.sv =====
// Self-checking testbench of the fixed block pool allocator: directed and random
// request beats, predicted against a free-list model of its own.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
`timescale 1ns / 100ps

module fixed_block_pool_allocator_test;
   import fbpa_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLDOFF_CYCLES = 150;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int RANDOM_ITEMS   = 510;
   localparam int REPORT_LINES   = 40;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [ADDR_W-1:0]       block_address;
      logic                    owned;
      logic [FREE_COUNT_W-1:0] free_count;
   } alloc_result_type;

   // DUT ports
   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [OP_W-1:0]         req_operation;
   logic [ADDR_W-1:0]       req_request_size;
   logic [ADDR_W-1:0]       req_address;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [STATUS_W-1:0]     rsp_status;
   logic [ADDR_W-1:0]       rsp_block_address;
   logic                    rsp_owned;
   logic [FREE_COUNT_W-1:0] rsp_free_count;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [ADDR_W-1:0]       csr_data;

   // Pool model state
   logic [ADDR_W-1:0]       pool_base_model;
   logic [CNT_W-1:0]        list_head;
   logic [CNT_W-1:0]        link_mem [NUM_BLOCKS];
   logic [CNT_W-1:0]        fresh_next;
   logic [FREE_COUNT_W-1:0] free_total;

   alloc_result_type  expected_results [$];
   alloc_result_type  oldest_result;
   logic [ADDR_W-1:0] live_blocks [$];

   int   error_count   = 0;
   int   cycle_count   = 0;
   int   req_idle_pct  = 0;
   int   rsp_idle_pct  = 0;
   logic holdoff_armed = 1'b0;

   fixed_block_pool_allocator u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_request_size  (req_request_size),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_block_address (rsp_block_address),
      .rsp_owned         (rsp_owned),
      .rsp_free_count    (rsp_free_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   // Clock
   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** fixed_block_pool_allocator: FAILED **");
      $finish;
   end

   // Pool model: state after reset
   task automatic reset_pool_model();
      pool_base_model = POOL_BASE_RESET;
      list_head       = LIST_END;
      fresh_next      = '0;
      free_total      = FREE_COUNT_W'(NUM_BLOCKS);
   endtask

   // Pool model: one operation, updates the state and gives the result beat
   task automatic predict_pool(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] size,
                               input logic [ADDR_W-1:0] addr, output alloc_result_type res);
      logic [ADDR_W:0]   range_lo;
      logic [ADDR_W:0]   range_hi;
      logic [ADDR_W-1:0] offset;
      logic [CNT_W-1:0]  idx;
      logic              got;
      range_lo          = {1'b0, pool_base_model};
      range_hi          = range_lo + (ADDR_W+1)'(POOL_BYTES);
      res.status        = STATUS_OK;
      res.block_address = '0;
      res.owned         = (addr != '0) && (pool_base_model != '0) &&
                          ({1'b0, addr} >= range_lo) && ({1'b0, addr} < range_hi);
      case (op)
         OP_ALLOC: begin
            if (size > BLOCK_BYTES) begin
               res.status = STATUS_TOO_LARGE;
            end else if (pool_base_model == '0) begin
               res.status = STATUS_EMPTY;
            end else begin
               got = 1'b1;
               idx = '0;
               if (list_head < LIST_END) begin
                  idx       = list_head;
                  list_head = link_mem[idx[IDX_W-1:0]];
                  if (list_head > LIST_END) list_head = LIST_END;
               end else if (fresh_next < LIST_END) begin
                  idx        = fresh_next;
                  fresh_next = fresh_next + 1'b1;
               end else begin
                  got = 1'b0;
               end
               if (got) begin
                  res.block_address = pool_base_model + (ADDR_W'(idx) << BLOCK_SHIFT);
                  if (free_total != '0) free_total = free_total - 1'b1;
               end else begin
                  res.status = STATUS_EMPTY;
               end
            end
         end
         OP_FREE: begin
            if (!res.owned) begin
               res.status = STATUS_IGNORED;
            end else begin
               offset = (addr - pool_base_model) >> BLOCK_SHIFT;
               if (offset < NUM_BLOCKS) begin
                  idx                        = CNT_W'(offset);
                  link_mem[idx[IDX_W-1:0]]   = list_head;
                  list_head                  = idx;
                  if (free_total < NUM_BLOCKS) free_total = free_total + 1'b1;
               end else begin
                  res.status = STATUS_IGNORED;
               end
            end
         end
         OP_RESET: begin
            list_head  = LIST_END;
            fresh_next = '0;
            free_total = FREE_COUNT_W'(NUM_BLOCKS);
         end
         default: ;
      endcase
      res.free_count = free_total;
   endtask

   task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] got,
                                  input logic [ADDR_W-1:0] want);
      if (error_count < REPORT_LINES)
         $display("mismatch on %s: got 0x%h, want 0x%h, cycle %0d",
                  field, got, want, cycle_count);
      error_count++;
   endtask

   // Result checker: every accepted beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected beat", rsp_block_address, '0);
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_status !== oldest_result.status)
               report_mismatch("status", rsp_status, oldest_result.status);
            if (rsp_block_address !== oldest_result.block_address)
               report_mismatch("block_address", rsp_block_address,
                               oldest_result.block_address);
            if (rsp_owned !== oldest_result.owned)
               report_mismatch("owned", rsp_owned, oldest_result.owned);
            if (rsp_free_count !== oldest_result.free_count)
               report_mismatch("free_count", rsp_free_count, oldest_result.free_count);
         end
      end
   end

   // Receiver stall: random, or a long hold-off once armed
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_armed) begin
            holdoff_armed = 1'b0;
            rsp_stall     = 1'b1;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
         end
         rsp_stall = ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Send one request beat, predict its result once accepted
   task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] size,
                               input logic [ADDR_W-1:0] addr);
      alloc_result_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_operation    = op;
      req_request_size = size;
      req_address      = addr;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_pool(op, size, addr, predicted);
      expected_results.push_back(predicted);
      if (op == OP_ALLOC && predicted.status == STATUS_OK)
         live_blocks.push_back(predicted.block_address);
      else if (op == OP_RESET)
         live_blocks.delete();
   endtask

   // Stop sending and let every outstanding result come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_pool_base(input logic [ADDR_W-1:0] value);
      wait_for_results();
      @(negedge clock);
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      pool_base_model = value;
      live_blocks.delete();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Address mix: null, random, in range, the edges of the range, block starts
   function automatic logic [ADDR_W-1:0] pick_address();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return $urandom;
         2:       return pool_base_model + $urandom_range(0, POOL_BYTES - 1);
         3:       return pool_base_model - 1;
         4:       return pool_base_model + POOL_BYTES;
         default: return pool_base_model + ($urandom_range(0, NUM_BLOCKS - 1) << BLOCK_SHIFT);
      endcase
   endfunction

   // One random beat; mostly well-formed allocates and frees of live blocks
   task automatic send_random_item(input int alloc_pct);
      int                roll;
      int                pick;
      logic [ADDR_W-1:0] size;
      logic [ADDR_W-1:0] addr;
      roll = $urandom_range(0, 99);
      size = $urandom;
      addr = pick_address();
      if (roll < alloc_pct) begin
         case ($urandom_range(0, 19))
            0, 1:    ;
            2:       size = BLOCK_BYTES + 1;
            default: size = $urandom_range(0, BLOCK_BYTES);
         endcase
         send_request(OP_ALLOC, size, addr);
      end else if (roll < alloc_pct + (97 - alloc_pct) * 2 / 3) begin
         if (live_blocks.size() != 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, live_blocks.size() - 1);
            addr = live_blocks[pick];
            live_blocks.delete(pick);
            if ($urandom_range(0, 3) == 0) addr = addr + $urandom_range(1, BLOCK_BYTES - 1);
         end
         send_request(OP_FREE, size, addr);
      end else if (roll < 98) begin
         send_request(OP_QUERY, size, addr);
      end else begin
         send_request(OP_RESET, size, addr);
      end
   endtask

   // Field extremes, every operation, misaligned and double frees
   task automatic test_directed_ops();
      logic [ADDR_W-1:0] base;
      base = POOL_BASE_RESET;
      send_request(OP_QUERY, '0, '0);
      send_request(OP_ALLOC, '0, '1);
      send_request(OP_ALLOC, BLOCK_BYTES, base);
      send_request(OP_ALLOC, BLOCK_BYTES + 1, base);
      send_request(OP_ALLOC, '1, '0);
      send_request(OP_FREE, '1, base + BLOCK_BYTES + 17);
      send_request(OP_FREE, '0, '0);
      send_request(OP_FREE, '0, base - 1);
      send_request(OP_FREE, '0, base + POOL_BYTES);
      send_request(OP_QUERY, '1, base + POOL_BYTES - 1);
      // same block freed twice is handed out by all three allocates that follow
      send_request(OP_FREE, '0, base);
      send_request(OP_FREE, '0, base);
      send_request(OP_ALLOC, 1, '0);
      send_request(OP_ALLOC, 1, '0);
      send_request(OP_ALLOC, 1, '0);
      send_request(OP_RESET, '1, '1);
      send_request(OP_QUERY, '0, '1);
      send_request(OP_ALLOC, 8, base);
   endtask

   // Absent pool, a pool wrapping past the top, the lowest base
   task automatic test_pool_base_extremes();
      write_pool_base('0);
      send_request(OP_ALLOC, 8, '0);
      send_request(OP_FREE, '0, 32'h40);
      send_request(OP_QUERY, '0, 32'h1000);
      write_pool_base('1);
      send_request(OP_RESET, '0, '0);
      send_request(OP_ALLOC, 8, '0);
      send_request(OP_ALLOC, 8, '0);
      send_request(OP_QUERY, '0, '1);
      send_request(OP_FREE, '0, '1);
      send_request(OP_FREE, '0, BLOCK_BYTES - 1);
      send_request(OP_ALLOC, 0, '0);
      write_pool_base(1);
      send_request(OP_ALLOC, BLOCK_BYTES, '0);
      send_request(OP_QUERY, '0, 1);
      send_request(OP_FREE, '0, POOL_BYTES);
      write_pool_base(POOL_BASE_RESET);
   endtask

   // Drain the whole pool; free count saturates at both ends
   task automatic test_exhaustion();
      send_request(OP_RESET, '0, '0);
      send_request(OP_FREE, '0, pool_base_model + 5 * BLOCK_BYTES);
      repeat (NUM_BLOCKS + 1) send_request(OP_ALLOC, $urandom_range(0, BLOCK_BYTES), $urandom);
      send_request(OP_ALLOC, 1, '0);
      send_request(OP_ALLOC, BLOCK_BYTES + 36, '0);
      send_request(OP_QUERY, '0, pool_base_model);
      send_request(OP_RESET, '0, '0);
   endtask

   task automatic test_random_traffic(input int count, input int req_pct, input int rsp_pct,
                                      input logic [ADDR_W-1:0] base);
      int alloc_pct;
      write_pool_base(base);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      alloc_pct    = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       alloc_pct = 30;
               1:       alloc_pct = 50;
               default: alloc_pct = 75;
            endcase
         end
         send_random_item(alloc_pct);
      end
   endtask

   // Receiver holds off while beats keep coming; the block fills and stalls
   task automatic test_backpressure_holdoff();
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      holdoff_armed = 1'b1;
      repeat (40) send_random_item(60);
   endtask

   // Sender stops until everything is back, then resumes
   task automatic test_sender_pause();
      req_idle_pct = 0;
      rsp_idle_pct = 30;
      repeat (20) send_random_item(50);
      wait_for_results();
      repeat (20) send_random_item(50);
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_ALLOC;
      req_request_size = '0;
      req_address      = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      reset_pool_model();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      test_pool_base_extremes();
      test_exhaustion();
      test_random_traffic(RANDOM_ITEMS, 14, 83, $urandom);
      test_random_traffic(RANDOM_ITEMS, 83, 14, 32'hFFFF_E000 + $urandom_range(0, 63));
      test_random_traffic(RANDOM_ITEMS, 0, 0, POOL_BASE_RESET);
      test_backpressure_holdoff();
      test_sender_pause();
      wait_for_results();

      if (error_count == 0)
         $display("** fixed_block_pool_allocator: PASSED **");
      else
         $display("** fixed_block_pool_allocator: FAILED **");
      $finish;
   end

endmodule
